@@ src/blq_pkg.sv @@
// Package with the sizes, codes, types and pointer helpers of the bounded list deque.
package blq_pkg;

   localparam int DEPTH = 16;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int NXT_W = PTR_W + 1;
   localparam int DATA_W = 32;
   localparam int CMD_W = 3;
   localparam int POS_W = 4;
   localparam int STATUS_W = 2;
   localparam int COUNT_W = 5;

   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [NXT_W-1:0] nxt_type;
   typedef logic [DATA_W-1:0] data_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_REMOVE     = 3'd4,
      CMD_READ       = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_FULL     = 2'd2,
      STATUS_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SCAN,
      ST_SHIFT,
      ST_RESP
   } state_type;

   // Store index of the entry at a given offset from the front, wrapping at DEPTH.
   function automatic ptr_type slot_add(input ptr_type base, input ptr_type off);
      nxt_type sum;
      sum = nxt_type'(base) + nxt_type'(off);
      if (sum >= nxt_type'(DEPTH)) begin
         sum = sum - nxt_type'(DEPTH);
      end
      return ptr_type'(sum);
   endfunction

   // Store index one place before the given one, wrapping at zero.
   function automatic ptr_type slot_prev(input ptr_type base);
      ptr_type prev;
      if (base == '0) begin
         prev = ptr_type'(DEPTH - 1);
      end else begin
         prev = base - 1'b1;
      end
      return prev;
   endfunction

endpackage

@@ src/blq_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module blq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/bounded_list_deque_unit.sv @@
// Bounded list deque: a circular store of signed words with front and back access.
// One command at a time: the next transfer is taken the cycle after the result leaves.
// Pushes, unused codes and refused commands go straight to the response; pops and reads
// first fetch the entry from the store, and removal by value scans, then shifts, through
// the single store.
// Synchronous reset empties the list; the store itself is not cleared.
module bounded_list_deque_unit
   import blq_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [CMD_W-1:0]           req_command,
   input  logic signed [DATA_W-1:0]   req_value,
   input  logic [POS_W-1:0]           req_position,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [DATA_W-1:0]   rsp_data_out,
   output logic [COUNT_W-1:0]         rsp_entry_count
);

   state_type  state_ff, state_in;
   ptr_type    fp_ff, fp_in;
   cnt_type    occ_ff, occ_in;
   cmd_type    cmd_ff, cmd_in;
   data_type   val_ff, val_in;
   ptr_type    idx_ff, idx_in;
   status_type status_ff, status_in;
   data_type   data_ff, data_in;

   logic       ram_wr_en;
   ptr_type    ram_wr_addr;
   data_type   ram_wr_data;
   ptr_type    ram_rd_addr;
   data_type   ram_rd_data;

   logic       is_full;
   logic       is_empty;
   logic       more_after_idx;
   logic       more_after_next;

   assign is_full = (occ_ff == cnt_type'(DEPTH));
   assign is_empty = (occ_ff == '0);
   assign more_after_idx = (nxt_type'(idx_ff) + nxt_type'(1) < nxt_type'(occ_ff));
   assign more_after_next = (nxt_type'(idx_ff) + nxt_type'(2) < nxt_type'(occ_ff));

   always_comb begin
      state_in = state_ff;
      fp_in = fp_ff;
      occ_in = occ_ff;
      cmd_in = cmd_ff;
      val_in = val_ff;
      idx_in = idx_ff;
      status_in = status_ff;
      data_in = data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in = cmd_type'(req_command);
               val_in = data_type'(req_value);
               idx_in = '0;
               status_in = STATUS_OK;
               data_in = '0;
               state_in = ST_RESP;
               unique case (cmd_type'(req_command))
                  CMD_PUSH_FRONT: begin
                     if (is_full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        fp_in = slot_prev(fp_ff);
                        occ_in = occ_ff + 1'b1;
                     end
                  end
                  CMD_PUSH_BACK: begin
                     if (is_full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        occ_in = occ_ff + 1'b1;
                     end
                  end
                  CMD_POP_FRONT, CMD_POP_BACK: begin
                     if (is_empty) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        state_in = ST_FETCH;
                     end
                  end
                  CMD_REMOVE: begin
                     if (is_empty) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  CMD_READ: begin
                     if (is_empty) begin
                        status_in = STATUS_EMPTY;
                     end else if (32'(req_position) >= 32'(occ_ff)) begin
                        status_in = STATUS_NOTFOUND;
                     end else begin
                        state_in = ST_FETCH;
                     end
                  end
                  default: begin
                     status_in = STATUS_OK;
                  end
               endcase
            end
         end
         ST_FETCH: begin
            data_in = ram_rd_data;
            state_in = ST_RESP;
            if (cmd_ff == CMD_POP_FRONT) begin
               fp_in = slot_add(fp_ff, ptr_type'(1));
               occ_in = occ_ff - 1'b1;
            end else if (cmd_ff == CMD_POP_BACK) begin
               occ_in = occ_ff - 1'b1;
            end
         end
         ST_SCAN: begin
            if (ram_rd_data == val_ff) begin
               data_in = ram_rd_data;
               if (more_after_idx) begin
                  state_in = ST_SHIFT;
               end else begin
                  occ_in = occ_ff - 1'b1;
                  state_in = ST_RESP;
               end
            end else if (more_after_idx) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               status_in = STATUS_NOTFOUND;
               state_in = ST_RESP;
            end
         end
         ST_SHIFT: begin
            idx_in = idx_ff + 1'b1;
            if (!more_after_next) begin
               occ_in = occ_ff - 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      ram_wr_en = 1'b0;
      ram_wr_addr = fp_ff;
      ram_wr_data = ram_rd_data;
      ram_rd_addr = fp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ram_wr_data = data_type'(req_value);
            unique case (cmd_type'(req_command))
               CMD_PUSH_FRONT: begin
                  ram_wr_en = req_valid && !is_full;
                  ram_wr_addr = slot_prev(fp_ff);
               end
               CMD_PUSH_BACK: begin
                  ram_wr_en = req_valid && !is_full;
                  ram_wr_addr = slot_add(fp_ff, ptr_type'(occ_ff));
               end
               CMD_POP_BACK: begin
                  ram_rd_addr = slot_add(fp_ff, ptr_type'(occ_ff - 1'b1));
               end
               CMD_READ: begin
                  ram_rd_addr = slot_add(fp_ff, ptr_type'(req_position));
               end
               default: begin
                  ram_rd_addr = fp_ff;
               end
            endcase
         end
         ST_SCAN: begin
            ram_rd_addr = slot_add(fp_ff, idx_ff + 1'b1);
         end
         ST_SHIFT: begin
            ram_wr_en = 1'b1;
            ram_wr_addr = slot_add(fp_ff, idx_ff);
            ram_rd_addr = slot_add(fp_ff, idx_ff + ptr_type'(2));
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fp_ff <= '0;
         occ_ff <= '0;
      end else begin
         state_ff <= state_in;
         fp_ff <= fp_in;
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      val_ff <= val_in;
      idx_ff <= idx_in;
      status_ff <= status_in;
      data_ff <= data_in;
   end

   blq_ram #(
      .WIDTH(DATA_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock(clock),
      .wr_en(ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign rsp_status = status_ff;
   assign rsp_data_out = data_ff;
   assign rsp_entry_count = COUNT_W'(occ_ff);

endmodule
